FILE: src/x86_64_instruction_byte_encoder_macros.svh
// assertion macros shared by the encoder modules
`ifndef X86_64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH
`define X86_64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define XENC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define XENC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define XENC_ASSERT(lbl, prop, msg)
`define XENC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/xenc_pkg.sv
package xenc_pkg;

    // position width of the output buffer
    localparam int POS_BITS = 32;
    localparam int MAX_BYTES = 16;
    localparam int SEQ_BITS = MAX_BYTES * 8;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // request codes
    localparam logic [4:0] OP_IMM      = 5'd0;
    localparam logic [4:0] OP_MOV      = 5'd1;
    localparam logic [4:0] OP_ADD      = 5'd2;
    localparam logic [4:0] OP_SUB      = 5'd3;
    localparam logic [4:0] OP_CMP      = 5'd4;
    localparam logic [4:0] OP_TEST     = 5'd5;
    localparam logic [4:0] OP_IMUL     = 5'd6;
    localparam logic [4:0] OP_IDIV     = 5'd7;
    localparam logic [4:0] OP_NEG      = 5'd8;
    localparam logic [4:0] OP_PUSH     = 5'd9;
    localparam logic [4:0] OP_POP      = 5'd10;
    localparam logic [4:0] OP_LOAD     = 5'd11;
    localparam logic [4:0] OP_STORE    = 5'd12;
    localparam logic [4:0] OP_LOADABS  = 5'd13;
    localparam logic [4:0] OP_STOREABS = 5'd14;
    localparam logic [4:0] OP_JMP      = 5'd15;
    localparam logic [4:0] OP_CALL     = 5'd16;
    localparam logic [4:0] OP_RET      = 5'd17;
    localparam logic [4:0] OP_JCC      = 5'd18;
    localparam logic [4:0] OP_PATCH    = 5'd19;
    localparam logic [4:0] OP_JMPTO    = 5'd20;
    localparam logic [4:0] OP_SETCC    = 5'd21;
    localparam logic [4:0] OP_PROLOGUE = 5'd22;
    localparam logic [4:0] OP_EPILOGUE = 5'd23;
    localparam logic [4:0] OP_ADDI8    = 5'd24;
    localparam logic [4:0] OP_SUBI8    = 5'd25;
    localparam logic [4:0] OP_PUSHR    = 5'd26;
    localparam logic [4:0] OP_POPR     = 5'd27;
    localparam logic [4:0] OP_MOVRR    = 5'd28;
    localparam logic [4:0] OP_ADDRR    = 5'd29;
    localparam logic [4:0] OP_SUBRR    = 5'd30;

    // machine code bytes
    localparam logic [7:0] B_REX_W   = 8'h48;
    localparam logic [7:0] B_REX_B   = 8'h41;
    localparam logic [7:0] B_MOV_RI  = 8'hB8;
    localparam logic [7:0] B_MOV_MI  = 8'hC7;
    localparam logic [7:0] B_ESC     = 8'h0F;
    localparam logic [7:0] B_JMP     = 8'hE9;
    localparam logic [7:0] B_CALL    = 8'hE8;
    localparam logic [7:0] B_CQO     = 8'h99;
    localparam logic [7:0] B_LEAVE   = 8'hC9;
    localparam logic [7:0] B_RET     = 8'hC3;
    localparam logic [7:0] B_JCC     = 8'h80;
    localparam logic [7:0] B_SETCC   = 8'h90;
    localparam logic [7:0] B_MOV_RM  = 8'h89;
    localparam logic [7:0] B_MOV_MR  = 8'h8B;
    localparam logic [7:0] B_ADD_RM  = 8'h01;
    localparam logic [7:0] B_SUB_RM  = 8'h29;
    localparam logic [7:0] B_CMP_RM  = 8'h39;
    localparam logic [7:0] B_TEST_RM = 8'h85;
    localparam logic [7:0] B_IMUL    = 8'hAF;
    localparam logic [7:0] B_GRP3    = 8'hF7;
    localparam logic [7:0] B_GRP1_32 = 8'h81;
    localparam logic [7:0] B_GRP1_8  = 8'h83;
    localparam logic [7:0] B_PUSH    = 8'h50;
    localparam logic [7:0] B_POP     = 8'h58;
    localparam logic [7:0] B_PUSH_BP = 8'h55;
    localparam logic [7:0] B_MOVZX   = 8'hB6;
    localparam logic [7:0] B_MODRM_AL = 8'hC0;

    // byte list, first byte in the low bits
    typedef struct packed {
        logic [SEQ_BITS-1:0] b;
        logic [4:0]          n;
    } t_seq;

    // one encoded request as it crosses the queue
    typedef struct packed {
        logic [SEQ_BITS-1:0] b;
        logic [3:0]          last_idx;
        logic                patch;
        logic                jmpto;
        logic [1:0]          fix_off;
        logic [31:0]         tgt;
    } t_item;

    function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    // append m bytes of s behind the bytes already in a
    function automatic t_seq app(t_seq a, logic [SEQ_BITS-1:0] s, logic [4:0] m);
        t_seq r;
        r.b = a.b | (s << {a.n, 3'b000});
        r.n = a.n + m;
        return r;
    endfunction

endpackage

FILE: src/xenc_if.sv
// request channel
interface xenc_req_if;
    import xenc_pkg::*;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic [3:0]         first_register;
    logic [3:0]         second_register;
    logic signed [63:0] immediate_value;
    logic [3:0]         condition_code;
    logic [31:0]        target_position;

    modport source (output valid, opcode, first_register, second_register,
                    immediate_value, condition_code, target_position, input ready);
    modport sink (input valid, opcode, first_register, second_register,
                  immediate_value, condition_code, target_position, output ready);
endinterface

// byte channel
interface xenc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [31:0] byte_position;
    logic        last_byte;
    logic [31:0] fixup_position;

    modport source (output valid, byte_value, byte_position, last_byte, fixup_position,
                    input ready);
    modport sink (input valid, byte_value, byte_position, last_byte, fixup_position,
                  output ready);
endinterface

FILE: src/xenc_front.sv
module xenc_front (
    xenc_req_if.sink        i_req,
    input  logic            i_full,
    output logic            o_push,
    output xenc_pkg::t_item o_item
);
    import xenc_pkg::*;

    logic [2:0]  r1l;
    logic [2:0]  r2l;
    logic [2:0]  mreg;
    logic [63:0] imm;
    logic [31:0] off;
    logic [7:0]  ldst_op;
    logic [7:0]  alu_op;
    logic [7:0]  rex;
    t_seq        mi;
    t_seq        s;

    assign r1l = i_req.first_register[2:0];
    assign r2l = i_req.second_register[2:0];
    assign imm = i_req.immediate_value;
    assign off = imm[31:0];
    assign mreg = (i_req.opcode == OP_IMM) ? r1l : 3'd0;

    // shortest move of the immediate
    always_comb begin
        mi = '0;
        if (imm[63:31] == '0) begin
            mi = app(mi, SEQ_BITS'({imm[31:0], B_MOV_RI + 8'(mreg)}), 5'd5);
        end else if (imm[63:31] == '1) begin
            mi = app(mi, SEQ_BITS'({imm[31:0], modrm(2'd3, 3'd0, mreg), B_MOV_MI, B_REX_W}),
                     5'd7);
        end else begin
            mi = app(mi, SEQ_BITS'({imm, B_MOV_RI + 8'(mreg), B_REX_W}), 5'd10);
        end
    end

    // opcode bytes that depend on the form
    always_comb begin
        case (i_req.opcode)
            OP_ADD, OP_ADDRR: alu_op = B_ADD_RM;
            OP_SUB, OP_SUBRR: alu_op = B_SUB_RM;
            OP_CMP:           alu_op = B_CMP_RM;
            OP_TEST:          alu_op = B_TEST_RM;
            default:          alu_op = B_MOV_RM;
        endcase
        ldst_op = (i_req.opcode == OP_LOAD) ? B_MOV_MR : B_MOV_RM;
        rex = {5'b01001, i_req.second_register[3], 1'b0, i_req.first_register[3]};
    end

    // byte list of the request
    always_comb begin
        s = '0;
        o_item = '0;
        o_item.tgt = i_req.target_position;
        case (i_req.opcode)
            OP_IMM: s = mi;
            OP_MOV, OP_ADD, OP_SUB, OP_CMP, OP_TEST:
                s = app(s, SEQ_BITS'({modrm(2'd3, r2l, r1l), alu_op, B_REX_W}), 5'd3);
            OP_IMUL:
                s = app(s, SEQ_BITS'({modrm(2'd3, r1l, r2l), B_IMUL, B_ESC, B_REX_W}), 5'd4);
            OP_IDIV:
                s = app(s, SEQ_BITS'({modrm(2'd3, 3'd7, r2l), B_GRP3, B_REX_W, B_CQO,
                                      B_REX_W}), 5'd5);
            OP_NEG:
                s = app(s, SEQ_BITS'({modrm(2'd3, 3'd3, r1l), B_GRP3, B_REX_W}), 5'd3);
            OP_PUSH: s = app(s, SEQ_BITS'(B_PUSH + 8'(r1l)), 5'd1);
            OP_POP:  s = app(s, SEQ_BITS'(B_POP + 8'(r1l)), 5'd1);
            OP_LOAD, OP_STORE: begin
                if (off[31:7] == '0 || off[31:7] == '1) begin
                    s = app(s, SEQ_BITS'({off[7:0], modrm(2'd1, r1l, 3'd5), ldst_op,
                                          B_REX_W}), 5'd4);
                end else begin
                    s = app(s, SEQ_BITS'({off, modrm(2'd2, r1l, 3'd5), ldst_op, B_REX_W}),
                            5'd7);
                end
            end
            OP_LOADABS: begin
                s = mi;
                s = app(s, SEQ_BITS'({modrm(2'd0, 3'd0, 3'd0), B_MOV_MR, B_REX_W}), 5'd3);
            end
            OP_STOREABS: begin
                s = app(s, SEQ_BITS'({modrm(2'd3, 3'd0, 3'd1), B_MOV_RM, B_REX_W}), 5'd3);
                s = app(s, mi.b, mi.n);
                s = app(s, SEQ_BITS'({modrm(2'd0, 3'd1, 3'd0), B_MOV_RM, B_REX_W}), 5'd3);
            end
            OP_JMP: begin
                s = app(s, SEQ_BITS'({32'd0, B_JMP}), 5'd5);
                o_item.fix_off = 2'd1;
            end
            OP_CALL: begin
                s = app(s, SEQ_BITS'({32'd0, B_CALL}), 5'd5);
                o_item.fix_off = 2'd1;
            end
            OP_RET: s = app(s, SEQ_BITS'(B_RET), 5'd1);
            OP_JCC: begin
                s = app(s, SEQ_BITS'({32'd0, B_JCC + 8'(i_req.condition_code), B_ESC}), 5'd6);
                o_item.fix_off = 2'd2;
            end
            OP_PATCH: begin
                s.n = 5'd4;
                o_item.patch = 1'b1;
            end
            OP_JMPTO: begin
                s = app(s, SEQ_BITS'({32'd0, B_JMP}), 5'd5);
                o_item.jmpto = 1'b1;
            end
            OP_SETCC:
                s = app(s, SEQ_BITS'({B_MODRM_AL, B_MOVZX, B_ESC, B_MODRM_AL,
                                      B_SETCC + 8'(i_req.condition_code), B_ESC}), 5'd6);
            OP_PROLOGUE: begin
                s = app(s, SEQ_BITS'({modrm(2'd3, 3'd4, 3'd5), B_MOV_RM, B_REX_W,
                                      B_PUSH_BP}), 5'd4);
                if (off != '0) begin
                    s = app(s, SEQ_BITS'({off, modrm(2'd3, 3'd5, 3'd4), B_GRP1_32, B_REX_W}),
                            5'd7);
                end
            end
            OP_EPILOGUE: s = app(s, SEQ_BITS'({B_RET, B_LEAVE}), 5'd2);
            OP_ADDI8:
                s = app(s, SEQ_BITS'({imm[7:0], modrm(2'd3, 3'd0, r1l), B_GRP1_8, B_REX_W}),
                        5'd4);
            OP_SUBI8:
                s = app(s, SEQ_BITS'({imm[7:0], modrm(2'd3, 3'd5, r1l), B_GRP1_8, B_REX_W}),
                        5'd4);
            OP_PUSHR, OP_POPR: begin
                if (i_req.first_register[3]) begin
                    s = app(s, SEQ_BITS'(B_REX_B), 5'd1);
                end
                s = app(s, SEQ_BITS'(((i_req.opcode == OP_PUSHR) ? B_PUSH : B_POP) + 8'(r1l)),
                        5'd1);
            end
            OP_MOVRR, OP_ADDRR, OP_SUBRR:
                s = app(s, SEQ_BITS'({modrm(2'd3, r2l, r1l), alu_op, rex}), 5'd3);
            default: s = '0;
        endcase
        o_item.b = s.b;
        o_item.last_idx = 4'(s.n - 5'd1);
    end

    // requests that emit nothing are dropped here
    assign i_req.ready = !i_full;
    assign o_push = i_req.valid && !i_full && (s.n != '0);

endmodule

FILE: src/xenc_fifo.sv
`include "x86_64_instruction_byte_encoder_macros.svh"

module xenc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xenc_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output xenc_pkg::t_item o_item
);
    import xenc_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    `XENC_ASSERT(a_no_overflow, !(i_push && o_full && !i_pop), "push into a full queue")
    `XENC_ASSERT(a_no_underflow, !(i_pop && o_empty), "pop from an empty queue")
    `XENC_ASSERT_ALWAYS(a_count_range, !i_rst_n || r_count <= Q_CNT_W'(Q_DEPTH), "bad count")
    `XENC_ASSERT(a_empty_ptrs, o_empty |-> (r_wr_ptr == r_rd_ptr), "empty queue with split pointers")

endmodule

FILE: src/xenc_back.sv
`include "x86_64_instruction_byte_encoder_macros.svh"

module xenc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  xenc_pkg::t_item i_item,
    output logic            o_pop,
    xenc_byte_if.source     o_byte
);
    import xenc_pkg::*;

    logic                r_busy;
    logic                r_prep;
    logic [3:0]          r_idx;
    t_item               r_it;
    logic [POS_BITS-1:0] r_wp;
    logic [POS_BITS-1:0] r_start;
    logic [31:0]         r_rel;
    logic                r_ov;
    logic [7:0]          r_obyte;
    logic [31:0]         r_opos;
    logic                r_olast;
    logic [31:0]         r_ofix;

    logic                out_free;
    logic                emit;
    logic                last;
    logic                done;
    logic                load;
    logic [POS_BITS-1:0] n_wp;
    logic [31:0]         wp32;
    logic                use_rel;
    logic [1:0]          rel_sel;
    logic [7:0]          byte_val;
    logic [31:0]         byte_pos;
    logic [31:0]         fix_pos;

    // handshake between stored word and output register
    assign out_free = !r_ov || o_byte.ready;
    assign emit     = r_busy && !r_prep && out_free;
    assign last     = (r_idx == r_it.last_idx);
    assign done     = emit && last;
    assign load     = !i_empty && (!r_busy || done);
    assign o_pop    = load;
    assign n_wp     = (emit && !r_it.patch) ? r_wp + 1'b1 : r_wp;
    assign wp32     = 32'(r_wp);

    // byte, position and fixup of the current word
    always_comb begin
        use_rel  = r_it.patch || (r_it.jmpto && r_idx != '0);
        rel_sel  = r_it.patch ? r_idx[1:0] : 2'(r_idx - 4'd1);
        byte_val = use_rel ? r_rel[{rel_sel, 3'b000} +: 8] : r_it.b[{r_idx, 3'b000} +: 8];
        byte_pos = r_it.patch ? 32'(POS_BITS'(r_it.tgt[POS_BITS-1:0] + POS_BITS'(r_idx)))
                              : wp32;
        fix_pos  = (r_it.fix_off != '0) ? 32'(POS_BITS'(r_start + POS_BITS'(r_it.fix_off)))
                                        : 32'd0;
    end

    // sequencer over the bytes of one request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_prep <= 1'b0;
            r_idx  <= '0;
            r_wp   <= '0;
        end else begin
            r_wp <= n_wp;
            if (load) begin
                r_busy <= 1'b1;
                r_prep <= i_item.patch;
                r_idx  <= '0;
            end else begin
                r_prep <= 1'b0;
                if (done) begin
                    r_busy <= 1'b0;
                end else if (emit) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // request payload and relative displacement
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_it    <= i_item;
            r_start <= n_wp;
        end
        if (r_busy && r_idx == '0) begin
            r_rel <= r_it.patch ? wp32 - r_it.tgt - 32'd4 : r_it.tgt - wp32 - 32'd5;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_byte.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= byte_val;
            r_opos  <= byte_pos;
            r_olast <= last;
            r_ofix  <= fix_pos;
        end
    end

    assign o_byte.valid          = r_ov;
    assign o_byte.byte_value     = r_obyte;
    assign o_byte.byte_position  = r_opos;
    assign o_byte.last_byte      = r_olast;
    assign o_byte.fixup_position = r_ofix;

    `XENC_ASSERT(a_prep_patch, r_prep |-> (r_busy && r_it.patch), "prep cycle outside a patch")
    `XENC_ASSERT(a_patch_holds, (emit && r_it.patch) |=> $stable(r_wp), "patch moved position")
    `XENC_ASSERT(a_idx_range, r_busy |-> (r_idx <= r_it.last_idx), "byte index past the end")
    `XENC_ASSERT(a_emit_advance, (emit && !r_it.patch) |=> (r_wp == $past(r_wp) + 1'b1),
                 "position did not advance")

endmodule

FILE: src/x86_64_instruction_byte_encoder.sv
// x86-64 instruction byte encoder. Each request word is encoded combinationally by the front
// end into a list of 1 to 16 bytes and placed in a two-entry queue; the back end then emits
// one byte word per cycle, unless the output is stalled, through a registered output, each
// with its buffer position, a last flag and the jump fixup position. A patch first works out
// its displacement before its bytes go out, and the back end takes the next request from the
// queue as it emits the last byte of the current one. Requests with the unused code emit
// nothing and are dropped at entry. The write position is held in the back end, starts at
// zero after reset and wraps at the buffer width.
module x86_64_instruction_byte_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xenc_req_if.sink    i_req,
    xenc_byte_if.source o_byte
);
    import xenc_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item f_item;
    t_item q_item;

    // classify and encode
    xenc_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_item (f_item)
    );

    // decoupling queue
    xenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    // byte emission
    xenc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule
